### design/mlbs_pkg.sv
// Shared types, constants and helpers for the multi-channel LED blink scheduler.
package mlbs_pkg;

	localparam int NUM_CHANNELS_DEF = 4;
	localparam int MAX_CHANNELS = 4;
	localparam logic [15:0] DEBOUNCE_RESET = 16'd20;

	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_BUTTON = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [2:0] CFG_ACTIVE = 3'd0;
	localparam logic [2:0] CFG_TIMING0 = 3'd1;
	localparam logic [2:0] CFG_TIMING1 = 3'd2;
	localparam logic [2:0] CFG_TIMING2 = 3'd3;
	localparam logic [2:0] CFG_TIMING3 = 3'd4;
	localparam logic [2:0] CFG_DEBOUNCE = 3'd5;

	typedef struct packed {
		logic [1:0] req_type;
		logic       button_level;
	} req_item_t;

	typedef struct packed {
		logic [3:0] led_pins;
		logic       blink_mode;
		logic       press_accepted;
	} res_item_t;

	typedef struct packed {
		logic step;
		logic tick;
		logic restart;
		logic active;
		logic mode;
	} chan_ctrl_t;

	function automatic logic [15:0] slot_time(input logic [63:0] timing, input logic mode,
		input logic off);
		logic [15:0] t;
		case ({mode, off})
			2'b00: t = timing[15:0];
			2'b01: t = timing[31:16];
			2'b10: t = timing[47:32];
			default: t = timing[63:48];
		endcase
		return t;
	endfunction

endpackage

### design/mlbs_channel.sv
// One blink channel: down-counter, lit flag and reload from the timing set.
module mlbs_channel (
	input  logic                clk,
	input  logic                arst_n,
	input  mlbs_pkg::chan_ctrl_t ctrl,
	input  logic [63:0]         timing,
	output logic                lit_next
);

	logic        lit_q;
	logic        lit_d;
	logic [15:0] count_q;
	logic [15:0] count_d;

	always_comb begin
		lit_d = lit_q;
		count_d = count_q;
		if (ctrl.active) begin
			if (ctrl.restart) begin
				lit_d = 1'b0;
				count_d = mlbs_pkg::slot_time(timing, ctrl.mode, 1'b1);
			end else if (ctrl.tick && count_q != 16'd0) begin
				if (count_q == 16'd1) begin
					// The channel toggles and reloads the time for its new state.
					lit_d = ~lit_q;
					count_d = mlbs_pkg::slot_time(timing, ctrl.mode, lit_q);
				end else begin
					count_d = count_q - 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q <= 1'b0;
			count_q <= 16'd0;
		end else if (ctrl.step) begin
			lit_q <= lit_d;
			count_q <= count_d;
		end
	end

	assign lit_next = lit_d;

endmodule

### design/multi_led_blink_scheduler_core.sv
// Top level of the multi-channel LED blink scheduler with its register port.
// The input register holds an accepted item until its result moves to the output register.
// One item per cycle unless stalled; all channels update in parallel in one pass.
// The input register and the result register each hold one item, so a new item
// is taken while a finished result waits to be collected.
// Reset clears valid flags and control state: channels dark, default mode, debounce 20.
module multi_led_blink_scheduler_core #(
	parameter int NUM_CHANNELS = mlbs_pkg::NUM_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  mlbs_pkg::req_item_t  req_item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output mlbs_pkg::res_item_t  res_item,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [5:0]           paddr,
	input  logic [63:0]          pwdata,
	output logic [63:0]          prdata,
	output logic                 pready
);

	logic [2:0]  active_q;
	logic [63:0] timing_q [mlbs_pkg::MAX_CHANNELS];
	logic [15:0] debounce_q;

	logic [2:0] cfg_idx;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_idx = paddr[5:3];
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 3'd0;
			debounce_q <= mlbs_pkg::DEBOUNCE_RESET;
			for (int i = 0; i < mlbs_pkg::MAX_CHANNELS; i++) begin
				timing_q[i] <= 64'd0;
			end
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				mlbs_pkg::CFG_ACTIVE: active_q <= pwdata[2:0];
				mlbs_pkg::CFG_TIMING0: timing_q[0] <= pwdata;
				mlbs_pkg::CFG_TIMING1: timing_q[1] <= pwdata;
				mlbs_pkg::CFG_TIMING2: timing_q[2] <= pwdata;
				mlbs_pkg::CFG_TIMING3: timing_q[3] <= pwdata;
				mlbs_pkg::CFG_DEBOUNCE: debounce_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			mlbs_pkg::CFG_ACTIVE: prdata = {61'd0, active_q};
			mlbs_pkg::CFG_TIMING0: prdata = timing_q[0];
			mlbs_pkg::CFG_TIMING1: prdata = timing_q[1];
			mlbs_pkg::CFG_TIMING2: prdata = timing_q[2];
			mlbs_pkg::CFG_TIMING3: prdata = timing_q[3];
			mlbs_pkg::CFG_DEBOUNCE: prdata = {48'd0, debounce_q};
			default: prdata = 64'd0;
		endcase
	end

	logic                valid_s1;
	mlbs_pkg::req_item_t item_s1;
	logic                out_free;
	logic                move;
	logic                req_take;

	assign out_free = !res_valid || !res_stall;
	assign move = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;
	assign req_take = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_take) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			item_s1 <= req_item;
		end
	end

	logic [31:0] tick_count_q;
	logic [31:0] last_press_q;
	logic        button_prev_q;
	logic        mode_q;
	logic [2:0]  used;
	logic        is_tick;
	logic        is_button;
	logic        is_restart;
	logic        press;
	logic        mode_d;

	assign used = (active_q > 3'(NUM_CHANNELS)) ? 3'(NUM_CHANNELS) : active_q;
	assign is_tick = item_s1.req_type == mlbs_pkg::REQ_TICK;
	assign is_button = item_s1.req_type == mlbs_pkg::REQ_BUTTON;
	assign is_restart = item_s1.req_type == mlbs_pkg::REQ_RESTART;
	assign press = is_button && button_prev_q && !item_s1.button_level &&
		((tick_count_q - last_press_q) > {16'd0, debounce_q});
	assign mode_d = mode_q ^ press;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= 32'd0;
			last_press_q <= 32'd0;
			button_prev_q <= 1'b1;
			mode_q <= 1'b0;
		end else if (move) begin
			if (is_tick) begin
				tick_count_q <= tick_count_q + 32'd1;
			end
			if (is_button) begin
				button_prev_q <= item_s1.button_level;
			end
			if (press) begin
				last_press_q <= tick_count_q;
			end
			mode_q <= mode_d;
		end
	end

	logic [NUM_CHANNELS-1:0] lit_next;
	logic [NUM_CHANNELS-1:0] chan_on;
	logic [3:0]              pins_d;

	for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
		mlbs_pkg::chan_ctrl_t ctrl;
		assign chan_on[g] = 3'(g) < used;
		assign ctrl = '{step: move, tick: is_tick, restart: is_restart,
			active: chan_on[g], mode: mode_q};
		mlbs_channel u_chan (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.timing   (timing_q[g]),
			.lit_next (lit_next[g])
		);
	end

	always_comb begin
		pins_d = 4'hF;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			pins_d[i] = !(chan_on[i] && lit_next[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (move) begin
			res_valid <= 1'b1;
		end else if (out_free) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			res_item <= '{led_pins: pins_d, blink_mode: mode_d, press_accepted: press};
		end
	end

	a_mode_only_on_button: assert property (@(posedge clk) disable iff (!arst_n)
		(move && !is_button) |=> $stable(mode_q))
		else $error("mode changed on an item that is not a button sample");

	a_press_only_on_button: assert property (@(posedge clk) disable iff (!arst_n)
		(move && !is_button) |=> !res_item.press_accepted)
		else $error("press reported on an item that is not a button sample");

	a_press_stamps_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(move && press) |=> (last_press_q == $past(tick_count_q)) && res_item.press_accepted)
		else $error("accepted press did not record the tick count");

	a_tick_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(move && is_tick) |=> (tick_count_q == $past(tick_count_q) + 32'd1) && res_valid)
		else $error("tick item did not advance the tick counter");

endmodule
